@@ hw/rtl/i2cras_pkg.sv @@
// Package for the I2C register access sequencer.
// Holds the state, command, status and control codes and the request and result structs.
// No dependencies.
package i2cras_pkg;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_START   = 4'd1,
        ST_ADDR_W  = 4'd2,
        ST_REG     = 4'd3,
        ST_TX_VAL  = 4'd4,
        ST_START_R = 4'd5,
        ST_ADDR_R  = 4'd6,
        ST_RX_1    = 4'd7,
        ST_RX_2    = 4'd8,
        ST_RX_BULK = 4'd9,
        ST_DONE    = 4'd10
    } t_state;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_ERROR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_INVALID = 2'd1,
        STS_BUSY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        BUS_NONE  = 2'd0,
        BUS_START = 2'd1,
        BUS_STOP  = 2'd2
    } t_bus;

    typedef enum logic [1:0] {
        CTL_KEEP  = 2'd0,
        CTL_SET   = 2'd1,
        CTL_CLEAR = 2'd2
    } t_ctl;

    localparam logic [7:0] C_ADDR_MAX     = 8'h7F;
    localparam logic [8:0] C_MAX_READ_LEN = 9'd255;
    localparam logic [7:0] C_BULK_TAIL    = 8'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_value;
        logic [7:0] rd_len;
        logic       flag_start_sent;
        logic       flag_addr_done;
        logic       flag_tx_empty;
        logic       flag_byte_done;
        logic       flag_rx_full;
        logic [7:0] rx_data0;
        logic [7:0] rx_data1;
    } t_req;

    typedef struct packed {
        logic [1:0] call_status;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] bus_ctl;
        logic [1:0] ack_ctl;
        logic [1:0] pos_ctl;
        logic [1:0] rx_count;
        logic [7:0] rx_first;
        logic [7:0] rx_second;
        logic       done_res;
        logic       failed;
        logic [3:0] fsm_state;
    } t_res;

endpackage

@@ hw/rtl/i2c_register_access_sequencer_core.sv @@
// Top level of the I2C register access sequencer.
// A request is registered, decoded against the held state and its result registered.
// Throughput: one request per cycle while i_ready does not stall the result stage,
// set by the single state update per request.
// Synchronous active-low reset returns the machine to idle and empties both stages.
// Depends on i2cras_pkg, i2cras_in_reg, i2cras_seq and i2cras_out_reg.
module i2c_register_access_sequencer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_dev_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_wr_value,
    input  logic [7:0] i_rd_len,
    input  logic       i_flag_start_sent,
    input  logic       i_flag_addr_done,
    input  logic       i_flag_tx_empty,
    input  logic       i_flag_byte_done,
    input  logic       i_flag_rx_full,
    input  logic [7:0] i_rx_data0,
    input  logic [7:0] i_rx_data1,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_call_status,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic [1:0] o_bus_ctl,
    output logic [1:0] o_ack_ctl,
    output logic [1:0] o_pos_ctl,
    output logic [1:0] o_rx_count,
    output logic [7:0] o_rx_first,
    output logic [7:0] o_rx_second,
    output logic       o_done_res,
    output logic       o_failed,
    output logic [3:0] o_fsm_state
);
    import i2cras_pkg::*;

    t_req in_req;
    t_req held_req;
    t_res seq_res;
    t_res out_res;
    logic held_valid;
    logic out_space;
    logic advance;

    assign in_req.cmd             = i_cmd;
    assign in_req.dev_addr        = i_dev_addr;
    assign in_req.reg_addr        = i_reg_addr;
    assign in_req.wr_value        = i_wr_value;
    assign in_req.rd_len          = i_rd_len;
    assign in_req.flag_start_sent = i_flag_start_sent;
    assign in_req.flag_addr_done  = i_flag_addr_done;
    assign in_req.flag_tx_empty   = i_flag_tx_empty;
    assign in_req.flag_byte_done  = i_flag_byte_done;
    assign in_req.flag_rx_full    = i_flag_rx_full;
    assign in_req.rx_data0        = i_rx_data0;
    assign in_req.rx_data1        = i_rx_data1;

    assign advance = held_valid && out_space;

    i2cras_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (in_req),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_req     (held_req)
    );

    i2cras_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_req     (held_req),
        .o_res     (seq_res)
    );

    i2cras_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (seq_res),
        .o_space (out_space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_call_status = out_res.call_status;
    assign o_tx_valid    = out_res.tx_valid;
    assign o_tx_byte     = out_res.tx_byte;
    assign o_bus_ctl     = out_res.bus_ctl;
    assign o_ack_ctl     = out_res.ack_ctl;
    assign o_pos_ctl     = out_res.pos_ctl;
    assign o_rx_count    = out_res.rx_count;
    assign o_rx_first    = out_res.rx_first;
    assign o_rx_second   = out_res.rx_second;
    assign o_done_res    = out_res.done_res;
    assign o_failed      = out_res.failed;
    assign o_fsm_state   = out_res.fsm_state;

endmodule

@@ hw/rtl/i2cras_in_reg.sv @@
// Input register stage of the I2C register access sequencer.
// Depends on i2cras_pkg for the request struct.
module i2cras_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  i2cras_pkg::t_req  i_req,
    input  logic              i_advance,
    output logic              o_valid,
    output i2cras_pkg::t_req  o_req
);
    import i2cras_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

@@ hw/rtl/i2cras_seq.sv @@
// Transaction state machine of the I2C register access sequencer.
// Holds the sequencer state and works out one result per request.
// Depends on i2cras_pkg.
module i2cras_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  i2cras_pkg::t_req  i_req,
    output i2cras_pkg::t_res  o_res
);
    import i2cras_pkg::*;

    t_state     r_state,       n_state;
    logic [6:0] r_target_addr, n_target_addr;
    logic [7:0] r_target_reg,  n_target_reg;
    logic [7:0] r_write_byte,  n_write_byte;
    logic       r_is_write,    n_is_write;
    logic [7:0] r_read_total,  n_read_total;
    logic [7:0] r_read_index,  n_read_index;
    logic       r_done,        n_done;
    logic       r_fail,        n_fail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_is_write <= 1'b0;
            r_done     <= 1'b0;
            r_fail     <= 1'b0;
        end else if (i_advance) begin
            r_state    <= n_state;
            r_is_write <= n_is_write;
            r_done     <= n_done;
            r_fail     <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_target_addr <= n_target_addr;
            r_target_reg  <= n_target_reg;
            r_write_byte  <= n_write_byte;
            r_read_total  <= n_read_total;
            r_read_index  <= n_read_index;
        end
    end

    always_comb begin
        logic       free_now;
        logic       bad;
        logic [7:0] remain;
        t_res       res;

        n_state       = r_state;
        n_target_addr = r_target_addr;
        n_target_reg  = r_target_reg;
        n_write_byte  = r_write_byte;
        n_is_write    = r_is_write;
        n_read_total  = r_read_total;
        n_read_index  = r_read_index;
        n_done        = r_done;
        n_fail        = r_fail;

        res           = '0;
        free_now      = (r_state == ST_IDLE) || (r_state == ST_DONE);
        bad           = (i_req.dev_addr > C_ADDR_MAX);
        remain        = (r_read_index < r_read_total) ? (r_read_total - r_read_index) : 8'd0;

        if (i_req.cmd == CMD_READ &&
            (i_req.rd_len == 8'd0 || {1'b0, i_req.rd_len} > C_MAX_READ_LEN)) begin
            bad = 1'b1;
        end

        unique case (t_cmd'(i_req.cmd))
            CMD_READ, CMD_WRITE: begin
                if (bad) begin
                    res.call_status = STS_INVALID;
                end else if (!free_now) begin
                    res.call_status = STS_BUSY;
                end else begin
                    n_target_addr = i_req.dev_addr[6:0];
                    n_target_reg  = i_req.reg_addr;
                    n_done        = 1'b0;
                    n_fail        = 1'b0;
                    n_state       = ST_START;
                    res.bus_ctl   = BUS_START;
                    if (i_req.cmd == CMD_READ) begin
                        n_is_write    = 1'b0;
                        n_read_total  = i_req.rd_len;
                        n_read_index  = 8'd0;
                        res.ack_ctl   = CTL_SET;
                    end else begin
                        n_is_write   = 1'b1;
                        n_write_byte = i_req.wr_value;
                    end
                end
            end
            CMD_ERROR: begin
                res.bus_ctl = BUS_STOP;
                res.pos_ctl = CTL_CLEAR;
                res.ack_ctl = CTL_SET;
                n_done      = 1'b1;
                n_fail      = 1'b1;
                n_state     = ST_DONE;
            end
            CMD_EVENT: begin
                unique case (r_state)
                    ST_START: begin
                        if (i_req.flag_start_sent) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = {r_target_addr, 1'b0};
                            n_state      = ST_ADDR_W;
                        end
                    end
                    ST_ADDR_W: begin
                        if (i_req.flag_addr_done) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = r_target_reg;
                            n_state      = ST_REG;
                        end
                    end
                    ST_REG: begin
                        if (r_is_write) begin
                            if (i_req.flag_tx_empty) begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = r_write_byte;
                                n_state      = ST_TX_VAL;
                            end
                        end else if (i_req.flag_byte_done && i_req.flag_tx_empty) begin
                            res.bus_ctl = BUS_START;
                            n_state     = ST_START_R;
                        end
                    end
                    ST_TX_VAL: begin
                        if (i_req.flag_byte_done && i_req.flag_tx_empty) begin
                            res.bus_ctl = BUS_STOP;
                            res.ack_ctl = CTL_SET;
                            n_done      = 1'b1;
                            n_fail      = 1'b0;
                            n_state     = ST_DONE;
                        end
                    end
                    ST_START_R: begin
                        if (i_req.flag_start_sent) begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = {r_target_addr, 1'b1};
                            n_state      = ST_ADDR_R;
                        end
                    end
                    ST_ADDR_R: begin
                        if (i_req.flag_addr_done) begin
                            if (r_read_total == 8'd1) begin
                                res.ack_ctl = CTL_CLEAR;
                                res.bus_ctl = BUS_STOP;
                                n_state     = ST_RX_1;
                            end else if (r_read_total == 8'd2) begin
                                res.pos_ctl = CTL_SET;
                                res.ack_ctl = CTL_CLEAR;
                                n_state     = ST_RX_2;
                            end else begin
                                res.ack_ctl = CTL_SET;
                                n_state     = ST_RX_BULK;
                            end
                        end
                    end
                    ST_RX_1: begin
                        if (i_req.flag_rx_full) begin
                            res.rx_count = 2'd1;
                            res.rx_first = i_req.rx_data0;
                            n_read_index = r_read_index + 8'd1;
                            res.ack_ctl  = CTL_SET;
                            n_done       = 1'b1;
                            n_fail       = 1'b0;
                            n_state      = ST_DONE;
                        end
                    end
                    ST_RX_2: begin
                        if (i_req.flag_byte_done) begin
                            res.bus_ctl   = BUS_STOP;
                            res.rx_count  = 2'd2;
                            res.rx_first  = i_req.rx_data0;
                            res.rx_second = i_req.rx_data1;
                            n_read_index  = r_read_index + 8'd2;
                            res.pos_ctl   = CTL_CLEAR;
                            res.ack_ctl   = CTL_SET;
                            n_done        = 1'b1;
                            n_fail        = 1'b0;
                            n_state       = ST_DONE;
                        end
                    end
                    ST_RX_BULK: begin
                        if (remain > C_BULK_TAIL) begin
                            if (i_req.flag_rx_full) begin
                                res.rx_count = 2'd1;
                                res.rx_first = i_req.rx_data0;
                                n_read_index = r_read_index + 8'd1;
                            end
                        end else if (remain == C_BULK_TAIL) begin
                            if (i_req.flag_byte_done) begin
                                res.ack_ctl  = CTL_CLEAR;
                                res.rx_count = 2'd1;
                                res.rx_first = i_req.rx_data0;
                                n_read_index = r_read_index + 8'd1;
                                n_state      = ST_RX_2;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        res.done_res  = n_done;
        res.failed    = n_fail;
        res.fsm_state = n_state;
        o_res         = res;
    end

endmodule

@@ hw/rtl/i2cras_out_reg.sv @@
// Result register stage of the I2C register access sequencer.
// Depends on i2cras_pkg for the result struct.
module i2cras_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  i2cras_pkg::t_res  i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output i2cras_pkg::t_res  o_res
);
    import i2cras_pkg::*;

    logic r_valid;
    t_res r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
